[rtl/cbcp_pkg.sv]
// Shared types and constants of the cubic Bezier closest-point block.
package cbcp_pkg;

  localparam int CW  = 32;   // coordinate width, signed Q16.16
  localparam int TW  = 17;   // parameter width, unsigned Q1.16
  localparam int TF  = 16;   // fractional bits of the parameter
  localparam int IW  = 8;    // iteration count width
  localparam int CXW = 38;   // width of B-P, B' and B'' before normalizing
  localparam int DOTW = 31;  // width of a normalized component
  localparam int MW  = 34;   // multiplier operand width
  localparam int PW  = 64;   // kept product and accumulator width
  localparam int QW  = 18;   // step magnitude width, up to 2.0 in Q.16
  localparam int NREG = 8;
  localparam int AW  = 5;    // APB address width

  localparam logic [TW-1:0] T_ONE   = TW'(1) << TF;
  localparam logic [QW-1:0] STEP_SAT = QW'(2) << TF;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    ST_CONV  = 2'd0,
    ST_FLAT  = 2'd1,
    ST_LIMIT = 2'd2
  } status_e;

  typedef struct packed {
    logic                 start;
    logic signed [PW-1:0] num;
    logic signed [PW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic          neg;
    logic [QW-1:0] mag;
  } div_rsp_t;

endpackage

[rtl/cbcp_mul.sv]
// Shared signed multiplier with a registered product.
module cbcp_mul import cbcp_pkg::*; (
  input  logic                 clk_i,
  input  logic signed [MW-1:0] a_i,
  input  logic signed [MW-1:0] b_i,
  output logic signed [PW-1:0] prod_o
);

  logic signed [2*MW-1:0] full;
  logic signed [PW-1:0]   prod_q;

  assign full = a_i * b_i;

  // All products used by the block fit the kept width.
  always_ff @(posedge clk_i) begin
    prod_q <= full[PW-1:0];
  end

  assign prod_o = prod_q;

endmodule

[rtl/cbcp_div.sv]
// Restoring divider that forms the Newton step N/S in Q.16, one bit a cycle.
module cbcp_div import cbcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic          busy_q, done_q, neg_q;
  logic [4:0]    cnt_q;
  logic [PW+1:0] r_q;
  logic [PW-1:0] d_q;
  logic [QW-1:0] q_q;

  logic [PW-1:0] un, ud;
  logic          sat, qbit;
  logic [PW+1:0] r_sub;

  assign un    = req_i.num[PW-1] ? PW'(-req_i.num) : PW'(req_i.num);
  assign ud    = req_i.den[PW-1] ? PW'(-req_i.den) : PW'(req_i.den);
  assign sat   = {1'b0, un} >= {ud, 1'b0};
  assign qbit  = r_q >= {2'b00, d_q};
  assign r_sub = qbit ? (r_q - {2'b00, d_q}) : r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        neg_q <= req_i.num[PW-1] ^ req_i.den[PW-1];
        d_q   <= ud;
        r_q   <= {2'b00, un};
        q_q   <= '0;
        cnt_q <= 5'(TF + 1);
        if (sat) begin
          q_q    <= STEP_SAT;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        r_q   <= {r_sub[PW:0], 1'b0};
        q_q   <= {q_q[QW-2:0], qbit};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.neg  = neg_q;
  assign rsp_o.mag  = q_q;

endmodule

[rtl/cbcp_core.sv]
// Sequencer and datapath of the Newton iteration around the shared multiplier.
module cbcp_core import cbcp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  coord_t          ctrl_i [NREG],
  input  logic            start_i,
  output logic            busy_o,
  input  coord_t          query_x_i,
  input  coord_t          query_y_i,
  input  logic [TW-1:0]   initial_t_i,
  input  logic [IW-1:0]   max_iterations_i,
  input  logic [TW-1:0]   tolerance_i,
  output logic            done_o,
  output logic [TW-1:0]   closest_t_o,
  output logic [1:0]      status_o,
  output logic [IW-1:0]   iterations_used_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_LMUL, S_LADD, S_DIFF, S_NORM, S_SHIFT,
    S_DMUL, S_DADD, S_FLAT, S_DIVW
  } state_e;

  state_e state_q;
  logic   done_q;
  logic [2:0] k_q, j_q, s_q;
  logic       axis_q;
  logic [TW-1:0] t_q, tol_q, res_t_q;
  logic [IW-1:0] maxit_q, iter_q, res_used_q;
  status_e       res_status_q;
  coord_t        px_q, py_q;
  coord_t                lv_q [6];
  logic signed [CXW-1:0] c_q  [6];
  logic signed [PW-1:0]  n_q, s2_q;

  // Lerp operands.
  coord_t la, lb;
  logic signed [CW:0] ld;
  always_comb begin
    case (k_q)
      3'd0:    begin la = ctrl_i[{2'd0, axis_q}]; lb = ctrl_i[{2'd1, axis_q}]; end
      3'd1:    begin la = ctrl_i[{2'd1, axis_q}]; lb = ctrl_i[{2'd2, axis_q}]; end
      3'd2:    begin la = ctrl_i[{2'd2, axis_q}]; lb = ctrl_i[{2'd3, axis_q}]; end
      3'd3:    begin la = lv_q[0]; lb = lv_q[1]; end
      3'd4:    begin la = lv_q[1]; lb = lv_q[2]; end
      3'd5:    begin la = lv_q[3]; lb = lv_q[4]; end
      default: begin la = '0; lb = '0; end
    endcase
  end
  assign ld = (CW+1)'(lb) - (CW+1)'(la);

  // Dot product operands.
  logic [2:0] ja, jb;
  always_comb begin
    case (j_q)
      3'd0:    begin ja = 3'd0; jb = 3'd2; end
      3'd1:    begin ja = 3'd1; jb = 3'd3; end
      3'd2:    begin ja = 3'd2; jb = 3'd2; end
      3'd3:    begin ja = 3'd3; jb = 3'd3; end
      3'd4:    begin ja = 3'd0; jb = 3'd4; end
      3'd5:    begin ja = 3'd1; jb = 3'd5; end
      default: begin ja = 3'd0; jb = 3'd0; end
    endcase
  end

  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_LMUL) begin
      ma = MW'(ld);
      mb = $signed(MW'(t_q));
    end else if (state_q == S_DMUL) begin
      ma = MW'($signed(c_q[ja][DOTW-1:0]));
      mb = MW'($signed(c_q[jb][DOTW-1:0]));
    end
  end

  cbcp_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .prod_o(prod));

  // Curve terms for the current axis.
  logic signed [CXW-1:0] e_q0, e_q1, e_q2, e_r0, e_r1, e_b, e_p, dv, acc;
  logic signed [CXW-1:0] c_pos, c_vel, c_acc;
  assign e_q0 = CXW'(lv_q[0]);
  assign e_q1 = CXW'(lv_q[1]);
  assign e_q2 = CXW'(lv_q[2]);
  assign e_r0 = CXW'(lv_q[3]);
  assign e_r1 = CXW'(lv_q[4]);
  assign e_b  = CXW'(lv_q[5]);
  assign e_p  = axis_q ? CXW'(py_q) : CXW'(px_q);
  assign dv    = e_r1 - e_r0;
  assign acc   = e_q2 - (e_q1 <<< 1) + e_q0;
  assign c_pos = e_b - e_p;
  assign c_vel = (dv <<< 1) + dv;
  assign c_acc = (acc <<< 2) + (acc <<< 1);

  // Common normalizing shift from the highest magnitude bit of all terms.
  logic [CXW-1:0] mor;
  logic [2:0]     s_new;
  always_comb begin
    mor = '0;
    for (int i = 0; i < 6; i++) begin
      mor = mor | (c_q[i][CXW-1] ? ~c_q[i] : c_q[i]);
    end
    s_new = '0;
    for (int b = DOTW - 1; b < CXW - 1; b++) begin
      if (mor[b]) s_new = 3'(b - (DOTW - 2));
    end
  end

  // Flat derivative test.
  logic [PW-1:0] as;
  logic [3:0]    eamt;
  logic          flat;
  assign as   = s2_q[PW-1] ? PW'(-s2_q) : PW'(s2_q);
  assign eamt = 4'd11 - {s_q, 1'b0};
  assign flat = (s_q <= 3'd5) ? ((as >> eamt) == '0) : (as == '0);

  div_req_t div_req;
  div_rsp_t div_rsp;
  assign div_req.start = (state_q == S_FLAT) && !flat;
  assign div_req.num   = n_q;
  assign div_req.den   = s2_q;

  cbcp_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // Parameter update.
  logic signed [QW+1:0] delta, nt;
  logic [TW-1:0]        nt_c;
  logic [QW-1:0]        step;
  logic [IW-1:0]        iter_n;
  always_comb begin
    delta = div_rsp.neg ? -$signed({2'b00, div_rsp.mag}) : $signed({2'b00, div_rsp.mag});
    nt    = $signed((QW+2)'(t_q)) - delta;
    if (nt < 0)                          nt_c = '0;
    else if (nt > $signed((QW+2)'(T_ONE))) nt_c = T_ONE;
    else                                 nt_c = nt[TW-1:0];
    step   = (t_q > nt_c) ? QW'(t_q - nt_c) : QW'(nt_c - t_q);
    iter_n = iter_q + IW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            px_q    <= query_x_i;
            py_q    <= query_y_i;
            maxit_q <= max_iterations_i;
            tol_q   <= tolerance_i;
            t_q     <= (initial_t_i > T_ONE) ? T_ONE : initial_t_i;
            iter_q  <= '0;
            k_q     <= '0;
            axis_q  <= 1'b0;
            if (max_iterations_i == '0) begin
              res_t_q      <= (initial_t_i > T_ONE) ? T_ONE : initial_t_i;
              res_status_q <= ST_LIMIT;
              res_used_q   <= '0;
              done_q       <= 1'b1;
            end else begin
              state_q <= S_LMUL;
            end
          end
        end
        S_LMUL: state_q <= S_LADD;
        S_LADD: begin
          lv_q[k_q] <= la + prod[TF+CW-1:TF];
          if (k_q == 3'd5) begin
            state_q <= S_DIFF;
          end else begin
            k_q     <= k_q + 3'd1;
            state_q <= S_LMUL;
          end
        end
        S_DIFF: begin
          k_q <= '0;
          if (axis_q) begin
            c_q[1]  <= c_pos;
            c_q[3]  <= c_vel;
            c_q[5]  <= c_acc;
            state_q <= S_NORM;
          end else begin
            c_q[0]  <= c_pos;
            c_q[2]  <= c_vel;
            c_q[4]  <= c_acc;
            axis_q  <= 1'b1;
            state_q <= S_LMUL;
          end
        end
        S_NORM: begin
          s_q     <= s_new;
          state_q <= S_SHIFT;
        end
        S_SHIFT: begin
          for (int i = 0; i < 6; i++) c_q[i] <= c_q[i] >>> s_q;
          j_q     <= '0;
          n_q     <= '0;
          s2_q    <= '0;
          state_q <= S_DMUL;
        end
        S_DMUL: state_q <= S_DADD;
        S_DADD: begin
          if (j_q < 3'd2) n_q  <= n_q + prod;
          else            s2_q <= s2_q + prod;
          if (j_q == 3'd5) begin
            state_q <= S_FLAT;
          end else begin
            j_q     <= j_q + 3'd1;
            state_q <= S_DMUL;
          end
        end
        S_FLAT: begin
          if (flat) begin
            res_t_q      <= t_q;
            res_status_q <= ST_FLAT;
            res_used_q   <= iter_q;
            done_q       <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            t_q <= nt_c;
            if (step < QW'(tol_q)) begin
              res_t_q      <= nt_c;
              res_status_q <= ST_CONV;
              res_used_q   <= iter_n;
              done_q       <= 1'b1;
              state_q      <= S_IDLE;
            end else if (iter_n == maxit_q) begin
              res_t_q      <= nt_c;
              res_status_q <= ST_LIMIT;
              res_used_q   <= maxit_q;
              done_q       <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              iter_q  <= iter_n;
              axis_q  <= 1'b0;
              k_q     <= '0;
              state_q <= S_LMUL;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign closest_t_o       = res_t_q;
  assign status_o          = res_status_q;
  assign iterations_used_o = res_used_q;

endmodule

[rtl/cubic_bezier_closest_point.sv]
// Top level of the cubic Bezier closest-point block: register port and core.
// The four control points are written over the APB-style port, one coordinate
// per 32-bit register at byte addresses 0 to 28 (x then y for each point).
// The user must write registers only while busy is low and no result is pending;
// the block itself does not enforce this. A query transfer is taken at a
// rising edge where start is high and busy is low. With a nonzero step limit
// the block then stays busy until the result is ready. Each Newton step runs
// through one shared multiplier: twelve lerps and six dot-product terms,
// differencing and normalizing, the flat-derivative test, and the 17-bit
// restoring division and taking its quotient. A step whose quotient
// saturates skips the division loop, and a step that stops flat ends after
// the flat-derivative test. A query with a zero step limit answers in the
// cycle after it is taken.
// The result transfer appears on closest_t_o, status_o and iterations_used_o
// for exactly one cycle with done_o high. The receiver cannot stall, so
// the result is lost if not taken then. busy falls in that same cycle, so a
// new query may be started right away.
// Reset clears the control points to zero and abandons any query in flight.
module cubic_bezier_closest_point import cbcp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [AW-1:0]   paddr,
  input  logic [CW-1:0]   pwdata,
  output logic [CW-1:0]   prdata,
  output logic            pready,
  input  logic            start,
  output logic            busy,
  input  coord_t          query_x_i,
  input  coord_t          query_y_i,
  input  logic [TW-1:0]   initial_t_i,
  input  logic [IW-1:0]   max_iterations_i,
  input  logic [TW-1:0]   tolerance_i,
  output logic            done_o,
  output logic [TW-1:0]   closest_t_o,
  output logic [1:0]      status_o,
  output logic [IW-1:0]   iterations_used_o
);

  coord_t     ctrl_q [NREG];
  logic [2:0] reg_idx;

  // Byte address bits one and zero are ignored.
  assign reg_idx = paddr[AW-1:2];
  assign pready  = 1'b1;
  assign prdata  = ctrl_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREG; i++) ctrl_q[i] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      ctrl_q[reg_idx] <= pwdata;
    end
  end

  cbcp_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl_q),
    .start_i           (start),
    .busy_o            (busy),
    .query_x_i         (query_x_i),
    .query_y_i         (query_y_i),
    .initial_t_i       (initial_t_i),
    .max_iterations_i  (max_iterations_i),
    .tolerance_i       (tolerance_i),
    .done_o            (done_o),
    .closest_t_o       (closest_t_o),
    .status_o          (status_o),
    .iterations_used_o (iterations_used_o)
  );

`ifndef ASSERT_OFF
  // A query taken with a nonzero step limit keeps the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && max_iterations_i != '0) |=> busy)
    else $error("block not busy after taking a query");

  // A result transfer always frees the block for the next query.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  // Convergence needs at least one step.
  a_conv_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_CONV) |-> iterations_used_o != '0)
    else $error("converged with no step taken");

  // The reported parameter stays within the unit interval.
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> closest_t_o <= T_ONE)
    else $error("closest_t out of range");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench of the cubic Bezier closest-point block.
`timescale 1ns / 100ps

module testbench;
  import cbcp_pkg::*;

  // Longest quiet stretch allowed: several times what a query with the largest
  // step limit takes.
  localparam int QUIET_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 20;
  localparam longint Q_ONE = 64'sd1 << TF;

  typedef struct {
    coord_t        qx;
    coord_t        qy;
    logic [TW-1:0] t0;
    logic [IW-1:0] steps;
    logic [TW-1:0] tol;
  } query_t;

  typedef struct {
    logic [TW-1:0] t;
    status_e       st;
    logic [IW-1:0] used;
  } answer_t;

  // One row of the directed table. A row with a typed answer checks against
  // it; every other row is checked against the predictor.
  typedef struct {
    int      curve;
    query_t  q;
    bit      typed;
    answer_t ans;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [AW-1:0]   paddr;
  logic [CW-1:0]   pwdata;
  logic [CW-1:0]   prdata;
  logic            pready;
  logic            start;
  logic            busy;
  coord_t          query_x_i;
  coord_t          query_y_i;
  logic [TW-1:0]   initial_t_i;
  logic [IW-1:0]   max_iterations_i;
  logic [TW-1:0]   tolerance_i;
  logic            done_o;
  logic [TW-1:0]   closest_t_o;
  logic [1:0]      status_o;
  logic [IW-1:0]   iterations_used_o;

  cubic_bezier_closest_point dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .query_x_i        (query_x_i),
    .query_y_i        (query_y_i),
    .initial_t_i      (initial_t_i),
    .max_iterations_i (max_iterations_i),
    .tolerance_i      (tolerance_i),
    .done_o           (done_o),
    .closest_t_o      (closest_t_o),
    .status_o         (status_o),
    .iterations_used_o(iterations_used_o)
  );

  // Our own copy of the control point registers, in register order.
  longint   ctrl_pts [NREG];
  answer_t  pending_answers [$];
  dir_row_t dir_rows [$];
  int       errors;
  int       quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Coordinates are kept as 64-bit signed integers in coordinate
  // LSBs; the parameter is an integer in [0, 2^TF].
  // ---------------------------------------------------------------------------

  // a + floor((b - a) * t / 2^TF), split so that no product overflows.
  function automatic longint bez_lerp(longint a, longint b, longint t);
    longint d, hi, lo;
    d  = b - a;
    hi = d >>> TF;
    lo = d - (hi <<< TF);
    return a + hi * t + ((lo * t) >>> TF);
  endfunction

  function automatic longint mag_of(longint x);
    return (x < 0) ? (-1 - x) : x;
  endfunction

  // Step N/D in Q.TF, truncated toward zero and saturated to 2.0.
  function automatic longint newton_ratio(longint n, longint d);
    longint unsigned un, ud, r, q;
    bit neg;
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    neg = (n < 0) != (d < 0);
    q   = un / ud;
    if (q >= 2) begin
      q = 64'd2 << TF;
    end else begin
      r = un % ud;
      for (int i = 0; i < TF; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 64'd1;
        end
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic answer_t predict_closest(query_t q);
    answer_t a;
    longint  t, px, py, nt, n, s2, step;
    longint  c [6];
    longint  lx [6];
    longint  ly [6];
    longint  m, as;
    int      sh, e;
    bit      flat;
    px = q.qx;
    py = q.qy;
    t  = (q.t0 > T_ONE) ? Q_ONE : longint'(q.t0);
    a.st   = ST_LIMIT;
    a.used = q.steps;
    for (int i = 0; i < int'(q.steps); i++) begin
      // de Casteljau levels per axis: q0 q1 q2 r0 r1 b.
      lx[0] = bez_lerp(ctrl_pts[0], ctrl_pts[2], t);
      lx[1] = bez_lerp(ctrl_pts[2], ctrl_pts[4], t);
      lx[2] = bez_lerp(ctrl_pts[4], ctrl_pts[6], t);
      ly[0] = bez_lerp(ctrl_pts[1], ctrl_pts[3], t);
      ly[1] = bez_lerp(ctrl_pts[3], ctrl_pts[5], t);
      ly[2] = bez_lerp(ctrl_pts[5], ctrl_pts[7], t);
      lx[3] = bez_lerp(lx[0], lx[1], t);
      lx[4] = bez_lerp(lx[1], lx[2], t);
      ly[3] = bez_lerp(ly[0], ly[1], t);
      ly[4] = bez_lerp(ly[1], ly[2], t);
      lx[5] = bez_lerp(lx[3], lx[4], t);
      ly[5] = bez_lerp(ly[3], ly[4], t);
      c[0] = lx[5] - px;
      c[1] = ly[5] - py;
      c[2] = 3 * (lx[4] - lx[3]);
      c[3] = 3 * (ly[4] - ly[3]);
      c[4] = 6 * (lx[2] - 2 * lx[1] + lx[0]);
      c[5] = 6 * (ly[2] - 2 * ly[1] + ly[0]);
      // Common normalizing shift that fits every component in 31 bits.
      m = 0;
      for (int k = 0; k < 6; k++) begin
        if (mag_of(c[k]) > m) m = mag_of(c[k]);
      end
      sh = 0;
      while ((m >>> sh) >= (64'sd1 << (DOTW - 1))) sh++;
      for (int k = 0; k < 6; k++) c[k] = c[k] >>> sh;
      n  = c[0] * c[2] + c[1] * c[3];
      s2 = c[2] * c[2] + c[3] * c[3] + c[0] * c[4] + c[1] * c[5];
      // The flat test compares |2*S| * 2^(2*sh) with 2^-20 squared units.
      as   = (s2 < 0) ? -s2 : s2;
      e    = 11 - 2 * sh;
      flat = (e <= 0) ? (as == 0) : (as < (64'sd1 << e));
      if (flat) begin
        a.st   = ST_FLAT;
        a.used = IW'(i);
        break;
      end
      nt = t - newton_ratio(n, s2);
      if (nt < 0) nt = 0;
      if (nt > Q_ONE) nt = Q_ONE;
      step = (t > nt) ? t - nt : nt - t;
      t = nt;
      if (step < longint'(q.tol)) begin
        a.st   = ST_CONV;
        a.used = IW'(i + 1);
        break;
      end
    end
    a.t = t[TW-1:0];
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. The receiver cannot stall, so every cycle with done_o
  // high is one result transfer, compared with the oldest expectation.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result transfer with no query outstanding");
      end else begin
        want = pending_answers.pop_front();
        if (closest_t_o !== want.t)
          report_mismatch($sformatf("closest_t %0d, expected %0d", closest_t_o, want.t));
        if (status_o !== want.st)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.st));
        if (iterations_used_o !== want.used)
          report_mismatch($sformatf("iterations_used %0d, expected %0d",
                                    iterations_used_o, want.used));
      end
    end
  end

  // The watchdog counts cycles in which no transfer of any kind takes place.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("cubic_bezier_closest_point test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Appends one row to the directed table.
  function automatic void add_row(dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Register write: a setup phase, then an access phase held until pready.
  task automatic write_ctrl_reg(int idx, logic [CW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    ctrl_pts[idx] = longint'(coord_t'(value));
  endtask

  // Control points may only change while the block is idle, so the sender
  // first drops start and waits until every outstanding result has come back.
  task automatic load_curve(coord_t pts [NREG]);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    for (int i = 0; i < NREG; i++) write_ctrl_reg(i, pts[i]);
  endtask

  // One query transfer. A gap of zero keeps start high straight into the
  // next query, so start is never lowered and raised in the same step.
  task automatic send_query(query_t q, int gap, bit typed, answer_t ans);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    query_x_i        <= q.qx;
    query_y_i        <= q.qy;
    initial_t_i      <= q.t0;
    max_iterations_i <= q.steps;
    tolerance_i      <= q.tol;
    do @(posedge clk_i); while (busy);
    pending_answers.insert(pending_answers.size(), typed ? ans : predict_closest(q));
  endtask

  function automatic coord_t rand_coord(int kind);
    case (kind)
      0: return coord_t'($urandom_range(0, 1 << 20)) - coord_t'(1 << 19);
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic query_t rand_query(int kind);
    query_t q;
    int pick;
    pick = $urandom_range(0, 9);
    q.qx = rand_coord((pick == 0) ? 2 : kind);
    q.qy = rand_coord((pick == 1) ? 2 : kind);
    pick = $urandom_range(0, 9);
    q.t0 = (pick == 0) ? TW'($urandom) : TW'($urandom_range(0, 1 << TF));
    pick = $urandom_range(0, 19);
    if (pick < 2)       q.steps = '0;
    else if (pick < 4)  q.steps = IW'($urandom_range(13, 255));
    else                q.steps = IW'($urandom_range(1, 12));
    pick = $urandom_range(0, 9);
    if (pick == 0)      q.tol = '0;
    else if (pick == 1) q.tol = TW'($urandom);
    else                q.tol = TW'($urandom_range(1, 2000));
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    coord_t   curve_lib [2][NREG];
    coord_t   pts [NREG];
    answer_t  none;
    int       cur_curve;
    int       kind;
    bit       no_idle;

    errors           = 0;
    quiet_cycles     = 0;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    start            <= 1'b0;
    query_x_i        <= '0;
    query_y_i        <= '0;
    initial_t_i      <= '0;
    max_iterations_i <= '0;
    tolerance_i      <= '0;
    for (int i = 0; i < NREG; i++) ctrl_pts[i] = 0;
    none = '{t: '0, st: ST_CONV, used: '0};

    // Curve 0 is the reset state, all points at the origin. Curve 1 is an
    // arch from (0,0) over (1,2) and (3,2) to (4,0).
    curve_lib[0] = '{default: '0};
    curve_lib[1] = '{32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000, 32'sh0002_0000,
                     32'sh0003_0000, 32'sh0002_0000, 32'sh0004_0000, 32'sh0000_0000};

    // With every point at the origin all derivatives vanish, so any query
    // with a nonzero step limit stops flat at its starting parameter.
    add_row('{0, '{0, 0, 0, 0, 0}, 1, '{0, ST_LIMIT, 0}});
    add_row('{0, '{0, 0, 17'h10000, 0, 1}, 1, '{17'h10000, ST_LIMIT, 0}});
    add_row('{0, '{0, 0, 17'h1FFFF, 0, 1}, 1, '{17'h10000, ST_LIMIT, 0}});
    add_row('{0, '{32'sh7FFF_FFFF, 32'sh8000_0000, 17'h08000, 5, 100},
              1, '{17'h08000, ST_FLAT, 0}});
    add_row('{0, '{32'sh8000_0000, 32'sh7FFF_FFFF, 17'h1FFFF, 255, 17'h1FFFF},
              1, '{17'h10000, ST_FLAT, 0}});
    add_row('{0, '{-1, -1, 17'h00001, 1, 0}, 1, '{17'h00001, ST_FLAT, 0}});
    add_row('{1, '{0, 0, 17'h1FFFF, 0, 0}, 1, '{17'h10000, ST_LIMIT, 0}});
    add_row('{1, '{32'sh0002_0000, 32'sh0003_0000, 17'h08000, 20, 16}, 0, none});
    add_row('{1, '{32'sh0002_0000, 32'sh0001_0000, 0, 20, 16}, 0, none});
    add_row('{1, '{32'sh0002_0000, 32'sh0001_0000, 17'h10000, 20, 16}, 0, none});
    add_row('{1, '{32'sh0001_0000, 32'sh0000_8000, 17'h1FFFF, 8, 4}, 0, none});
    // Zero tolerance runs into the step limit.
    add_row('{1, '{32'sh0003_0000, 32'sh0001_0000, 17'h04000, 255, 0}, 0, none});
    add_row('{1, '{32'sh0003_0000, 32'sh0001_0000, 17'h04000, 1, 17'h1FFFF},
              0, none});
    add_row('{1, '{32'sh0003_0000, 32'sh0001_0000, 17'h04000, 1, 1}, 0, none});
    add_row('{1, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 17'h0C000, 12, 2}, 0, none});
    add_row('{1, '{32'sh8000_0000, 32'sh8000_0000, 17'h02000, 12, 2}, 0, none});
    add_row('{1, '{32'sh8000_0000, 32'sh7FFF_FFFF, 17'h1C000, 12, 2}, 0, none});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_curve = 0;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].curve != cur_curve) begin
        cur_curve = dir_rows[r].curve;
        load_curve(curve_lib[cur_curve]);
      end
      send_query(dir_rows[r].q, $urandom_range(0, 10), dir_rows[r].typed, dir_rows[r].ans);
    end

    // Random phases, each under a new curve. Kind 0 keeps coordinates within
    // eight units, kind 1 puts them at the extremes, kind 2 spans the range,
    // and kind 3 collapses all points into one so that queries stop flat.
    for (int ph = 0; ph < 6; ph++) begin
      kind = (ph == 5) ? 0 : ph % 4;
      for (int i = 0; i < NREG; i++) pts[i] = rand_coord((kind == 3) ? 2 : kind);
      if (kind == 3) begin
        for (int i = 2; i < NREG; i++) pts[i] = pts[i % 2];
      end
      load_curve(pts);
      for (int n = 0; n < 75; n++) begin
        // Bursts with no idling at all, mixed with randomly spaced queries.
        if (n % 15 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_query(rand_query((kind == 3) ? 0 : kind),
                   no_idle ? 0 : $urandom_range(0, 10), 0, none);
      end
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("cubic_bezier_closest_point test passed");
    end else begin
      $display("cubic_bezier_closest_point test failed");
    end
    $finish;
  end

endmodule
